// ----- rtl/core/size_keyed_quad_cache_core_macros.svh -----
// Assertion macros shared by the quad cache RTL.
`ifndef SIZE_KEYED_QUAD_CACHE_CORE_MACROS_SVH
`define SIZE_KEYED_QUAD_CACHE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SKQC_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("skqc assertion failed");
// next-cycle implication
`define SKQC_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("skqc assertion failed");
`else
`define SKQC_ASSERT_IMP(label, clk, rst_n, a, b)
`define SKQC_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

// ----- rtl/core/skqc_pkg.sv -----
package skqc_pkg;

  // request commands
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_HIT   = 3'd0;
  localparam logic [2:0] ST_ALLOC = 3'd1;
  localparam logic [2:0] ST_LARGE = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_TICK  = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_AREA_LIMIT = 2'd0;
  localparam logic [1:0] CFG_LIFETIME   = 2'd1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [14:0] AREA_LIMIT_RST = 15'd2048;
  localparam logic [4:0]  LIFETIME_RST   = 5'd31;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] width;
    logic [7:0] height;
    logic [5:0] hint_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  index;
    logic [6:0]  half_width;
    logic [13:0] tex_s_end;
    logic [13:0] tex_t_end;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic commit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic nop;
  } dp_sts_t;

endpackage

// ----- rtl/core/size_keyed_quad_cache_core.sv -----
// A request is taken, searched in the next cycle, and its result is written
// into the output register once that register is free to take it.
// A new request is not taken until the current one leaves the search step
// of the controller's capture/search sequence; a stalled output holds the search step.
// Reset (rst_n, synchronous): all entries free, registers to 2048 and 31.
module size_keyed_quad_cache_core import skqc_pkg::*; #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  req_t                  in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rsp_t                  out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  skqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  skqc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sts       (sts),
    .out_rsp   (out_rsp)
  );

endmodule

// ----- rtl/core/skqc_dp.sv -----
`include "size_keyed_quad_cache_core_macros.svh"

module skqc_dp import skqc_pkg::*; #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  req_t                  in_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  ctl_cmd_t              ctl,
  output dp_sts_t               sts,
  output rsp_t                  out_rsp
);

  // configuration registers
  logic [14:0] area_limit_r;
  logic [4:0]  lifetime_r;

  // captured request
  logic [1:0]  cmd_r;
  logic [7:0]  width_r;
  logic [7:0]  height_r;
  logic [15:0] prod_r;

  // entry cells
  logic [ENTRIES-1:0] valid_r;
  logic [15:0]        key_r [ENTRIES];
  logic [4:0]         age_r [ENTRIES];

  logic [15:0]        key;
  logic               too_large;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] hit_oh;
  logic [ENTRIES-1:0] free_oh;
  logic               any_hit;
  logic               any_free;
  logic [5:0]         hit_idx;
  logic [5:0]         free_idx;
  logic               do_lookup;
  logic               do_tick;
  logic               do_clear;
  rsp_t               rsp_nxt;
  rsp_t               rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_limit_r <= AREA_LIMIT_RST;
      lifetime_r   <= LIFETIME_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_AREA_LIMIT) begin
        area_limit_r <= cfg_wdata[14:0];
      end else if (cfg_index == CFG_LIFETIME) begin
        lifetime_r <= cfg_wdata[4:0];
      end
    end
  end

  // request capture; area product is registered ahead of the compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_NOP;
    end else if (ctl.load) begin
      cmd_r <= in_req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      width_r  <= in_req.width;
      height_r <= in_req.height;
      prod_r   <= 16'(in_req.width) * 16'(in_req.height);
    end
  end

  assign key       = {width_r, height_r};
  assign too_large = prod_r[15:1] > area_limit_r;
  assign sts.nop   = (cmd_r == CMD_NOP);

  // per-entry match and free flags
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_r[i] == key);
    end
  end
  assign free_vec = ~valid_r;

  // lowest set bit wins
  assign hit_oh   = hit_vec & (~hit_vec + ENTRIES'(1));
  assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) hit_idx = hit_idx | 6'(i);
      if (free_oh[i]) free_idx = free_idx | 6'(i);
    end
  end

  assign do_lookup = ctl.commit && (cmd_r == CMD_LOOKUP) && !too_large;
  assign do_tick   = ctl.commit && (cmd_r == CMD_TICK);
  assign do_clear  = ctl.commit && (cmd_r == CMD_CLEAR);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_clear) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_tick && valid_r[i] && (age_r[i] <= 5'd1)) begin
          valid_r[i] <= 1'b0;
        end else if (do_lookup && !any_hit && free_oh[i]) begin
          valid_r[i] <= 1'b1;
        end
      end
    end
  end

  // key and age payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_tick && valid_r[i] && (age_r[i] > 5'd1)) begin
        age_r[i] <= age_r[i] - 5'd1;
      end else if (do_lookup && any_hit && hit_oh[i]) begin
        age_r[i] <= lifetime_r;
      end else if (do_lookup && !any_hit && free_oh[i]) begin
        age_r[i] <= lifetime_r;
        key_r[i] <= key;
      end
    end
  end

  // result formation
  always_comb begin
    rsp_nxt = '0;
    unique case (cmd_r)
      CMD_LOOKUP: begin
        if (too_large) begin
          rsp_nxt.status = ST_LARGE;
        end else if (any_hit) begin
          rsp_nxt.status = ST_HIT;
          rsp_nxt.index  = hit_idx;
        end else if (any_free) begin
          rsp_nxt.status     = ST_ALLOC;
          rsp_nxt.index      = free_idx;
          rsp_nxt.half_width = width_r[7:1];
          rsp_nxt.tex_s_end  = {1'b1, width_r, 5'd0};
          rsp_nxt.tex_t_end  = {1'b1, height_r, 5'd0};
        end else begin
          rsp_nxt.status = ST_FULL;
        end
      end
      CMD_TICK:  rsp_nxt.status = ST_TICK;
      CMD_CLEAR: rsp_nxt.status = ST_CLEAR;
      default:   rsp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp = rsp_r;

  // a lookup never both hits and allocates
  `SKQC_ASSERT_NXT(a_hit_onehot, clk, rst_n, do_lookup && any_hit, $countones(valid_r) == $past($countones(valid_r)))
  // clear empties every entry
  `SKQC_ASSERT_NXT(a_clear_empty, clk, rst_n, do_clear, valid_r == '0)
  // allocation fills exactly one free entry
  `SKQC_ASSERT_NXT(a_alloc_one, clk, rst_n, do_lookup && !any_hit && any_free, $countones(valid_r) == $past($countones(valid_r)) + 1)

endmodule

// ----- rtl/core/skqc_ctrl.sv -----
`include "size_keyed_quad_cache_core_macros.svh"

module skqc_ctrl import skqc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_sts_t  sts,
  output ctl_cmd_t ctl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic accept;
  logic slot_free;
  logic commit;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  // output register can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.nop) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign ctl.load   = accept;
  assign ctl.commit = commit;

  `SKQC_ASSERT_NXT(a_accept_exec, clk, rst_n, accept, state_r == ST_EXEC)
  `SKQC_ASSERT_NXT(a_commit_valid, clk, rst_n, commit, out_valid_r)
  `SKQC_ASSERT_IMP(a_commit_slot, clk, rst_n, commit, state_r == ST_EXEC && slot_free)
  `SKQC_ASSERT_NXT(a_wait_slot, clk, rst_n, state_r == ST_EXEC && !sts.nop && !slot_free, state_r == ST_EXEC)

endmodule
